FILE: rtl/rgbhsi_pkg.sv
// Types and constants for the pixel color converter.
// Used by every module under rtl; depends on nothing.
package rgbhsi_pkg;
  localparam int unsigned NumIter = 20;
  // Vector components: 10 integer bits plus Q24 plus growth margin
  localparam int unsigned VecW = 38;
  localparam int unsigned AccW = 26;   // signed degrees Q16
  localparam int unsigned SumW = 10;
  // Saturation divider: dividend, divisor and quotient widths
  localparam int unsigned RemW = 19;
  localparam int unsigned DenW = 11;
  localparam int unsigned QuoW = 8;
  localparam logic signed [VecW-1:0] Sqrt3Q24 = 38'sd29058991;
  localparam logic signed [AccW-1:0] Deg90 = 26'sd5898240;
  localparam logic signed [AccW-1:0] Deg180 = 26'sd11796480;
  localparam logic [AccW-1:0] Deg360 = 26'd23592960;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AccW-1:0] acc;
    logic                   grey;
    logic                   mirror;
    logic [RemW-1:0]        rem;
    logic [DenW-1:0]        den;
    logic [QuoW-1:0]        quo;
    logic [7:0]             inten;
  } cell_t;

  function automatic logic signed [AccW-1:0] atan_q16(input int unsigned i);
    logic signed [AccW-1:0] t;
    begin
      unique case (i)
        0: t = 26'sd2949120;   1: t = 26'sd1740967;   2: t = 26'sd919879;
        3: t = 26'sd466945;    4: t = 26'sd234379;    5: t = 26'sd117304;
        6: t = 26'sd58666;     7: t = 26'sd29335;     8: t = 26'sd14668;
        9: t = 26'sd7334;      10: t = 26'sd3667;     11: t = 26'sd1833;
        12: t = 26'sd917;      13: t = 26'sd458;      14: t = 26'sd229;
        15: t = 26'sd115;      16: t = 26'sd57;       17: t = 26'sd29;
        18: t = 26'sd14;       default: t = 26'sd7;
      endcase
      return t;
    end
  endfunction

  // Shift rounding toward zero
  function automatic logic signed [VecW-1:0] shr_tz(input logic signed [VecW-1:0] v,
                                                   input int unsigned s);
    logic [VecW-1:0] m;
    begin
      m = v[VecW-1] ? VecW'(-v) : VecW'(v);
      m = m >> s;
      return v[VecW-1] ? -$signed(m) : $signed(m);
    end
  endfunction
endpackage

FILE: rtl/rgbhsi_front.sv
// Input stage: CORDIC vector setup, saturation divider setup and intensity.
// Depends on rgbhsi_pkg.
module rgbhsi_front import rgbhsi_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  output cell_t      q
);
  logic [SumW-1:0] sum;
  logic [7:0] mn;
  logic [SumW-1:0] num;
  logic [RemW-1:0] snum;
  logic [DenW-1:0] den;
  logic [10:0] iq;
  logic signed [VecW-1:0] x0, y0, xs, ys;
  logic signed [10:0] d;
  logic [7:0] ad;
  cell_t c;

  always_comb begin
    sum = SumW'(blue) + SumW'(green) + SumW'(red);
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    num = sum - SumW'(3) * SumW'(mn);
    snum = RemW'(num) * RemW'(510) + RemW'(sum);
    // Black pixel: unit divisor over a zero dividend gives saturation zero
    den = (sum == '0) ? DenW'(1) : {sum, 1'b0};
    iq = 11'((21'(sum) + 21'd1) * 21'd683 >> 11);
    d = 11'(green) - 11'(blue);
    ad = d[10] ? 8'(-d) : 8'(d);
    x0 = VecW'(11'sd2 * $signed({3'b0, red}) - $signed({3'b0, green})
               - $signed({3'b0, blue})) <<< 24;
    y0 = $signed(VecW'(ad)) * Sqrt3Q24;
    c.grey = (red == green) && (green == blue);
    c.mirror = blue > green;
    c.rem = snum;
    c.den = den;
    c.quo = '0;
    c.inten = (iq > 11'd255) ? 8'd255 : iq[7:0];
    if (x0 < 0) begin
      xs = y0; ys = -x0; c.acc = Deg90;
    end else begin
      xs = x0; ys = y0; c.acc = '0;
    end
    c.x = xs;
    c.y = ys;
  end

  always_ff @(posedge clk) begin
    if (en) q <= c;
  end
endmodule

FILE: rtl/rgbhsi_cell.sv
// One CORDIC vectoring rotation with fixed shift; the first cells also
// resolve one saturation quotient bit each. Depends on rgbhsi_pkg.
module rgbhsi_cell import rgbhsi_pkg::*; #(
  parameter int unsigned Stage = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cell_t d,
  output cell_t q
);
  localparam bit DivOn = (Stage < QuoW);
  localparam int unsigned DivBit = DivOn ? QuoW - 1 - Stage : 0;

  cell_t n;
  logic signed [VecW-1:0] xs, ys;
  logic [RemW-1:0] dsh;

  always_comb begin
    n = d;
    xs = shr_tz(d.x, Stage);
    ys = shr_tz(d.y, Stage);
    if (d.y > 0) begin
      n.x = d.x + ys; n.y = d.y - xs; n.acc = d.acc + atan_q16(Stage);
    end else begin
      n.x = d.x - ys; n.y = d.y + xs; n.acc = d.acc - atan_q16(Stage);
    end
    // Restoring division, most significant quotient bit first
    dsh = RemW'(d.den) << DivBit;
    if (DivOn && (d.rem >= dsh)) begin
      n.rem = d.rem - dsh;
      n.quo[DivBit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= n;
  end
endmodule

FILE: rtl/rgb_to_hsi_pixel.sv
// Top level: pipelined RGB to HSI pixel converter.
// Depends on rgbhsi_pkg, rgbhsi_front, rgbhsi_cell.
//
//  channel | ports                                   | dir
//  input   | in_valid in_ready in_blue/green/red     | in
//  result  | out_valid out_ready out_hue_half_deg    | out
//          | out_saturation out_intensity            |
//
// One pixel per cycle while the output is not stalled. The pipeline is the setup stage,
// one CORDIC cell per iteration, then the output register with hue rounding
// in front of it. The first eight cells also divide out the saturation.
// The whole row advances together; it holds when the output is full and stalled.
// Synchronous active-low reset clears only the valid bits.
module rgb_to_hsi_pixel import rgbhsi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_green,
  input  logic [7:0] in_red,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_hue_half_deg,
  output logic [7:0] out_saturation,
  output logic [7:0] out_intensity
);
  localparam int unsigned Depth = NumIter + 2;

  logic adv;
  logic [Depth-1:0] vld_r, vld_nxt;
  cell_t chain [NumIter+1];
  logic [7:0] hue_nxt, hue_r, sat_r, int_r;
  logic signed [AccW-1:0] a;
  logic [AccW-1:0] h, hq;

  // Advance the whole row unless the output holds a stalled transaction
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[Depth-1];

  rgbhsi_front u_front (
    .clk(clk), .en(adv), .blue(in_blue), .green(in_green), .red(in_red),
    .q(chain[0])
  );

  for (genvar i = 0; i < NumIter; i++) begin : g_cell
    rgbhsi_cell #(.Stage(i)) u_cell (
      .clk(clk), .en(adv), .d(chain[i]), .q(chain[i+1])
    );
  end

  always_comb begin
    a = chain[NumIter].acc;
    if (a < 0) a = '0;
    if (a > Deg180) a = Deg180;
    h = chain[NumIter].mirror ? Deg360 - AccW'(a) : AccW'(a);
    hq = (h + AccW'(65536)) >> 17;
    hue_nxt = chain[NumIter].grey ? 8'd0 : hq[7:0];
    vld_nxt = {vld_r[Depth-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r <= hue_nxt;
      sat_r <= chain[NumIter].quo;
      int_r <= chain[NumIter].inten;
    end
  end

  assign out_hue_half_deg = hue_r;
  assign out_saturation = sat_r;
  assign out_intensity = int_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hue_half_deg))
    else $error("result changed while stalled");
  a_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_half_deg <= 8'd180)
    else $error("hue out of range");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("stalled with empty output");
endmodule

FILE: test/tb_rgb_to_hsi_pixel.sv
// Testbench for the pipelined RGB to HSI pixel converter.
// Depends on rgbhsi_pkg and rgb_to_hsi_pixel under rtl; self-checking, no files.
`timescale 1ns / 100ps

// Predicts hue, saturation and intensity for each accepted pixel and checks results in order.
class hsi_scoreboard;
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] inten;
  } hsi_t;

  hsi_t pending[$];
  int   errors;

  static function longint shift_to_zero(longint v, int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  // Vectoring CORDIC: atan2(y, x) for y >= 0, degrees in Q16, clamped to 0..180.
  static function longint cordic_angle(longint x0, longint y0);
    longint x, y, acc, xs, ys, t;
    longint step_tab[20];
    step_tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    x = x0; y = y0; acc = 0;
    if (x < 0) begin
      t = x; x = y; y = -t; acc = 90 * 65536;
    end
    for (int i = 0; i < 20; i++) begin
      xs = shift_to_zero(x, i);
      ys = shift_to_zero(y, i);
      if (y > 0) begin
        x += ys; y -= xs; acc += step_tab[i];
      end else begin
        x -= ys; y += xs; acc -= step_tab[i];
      end
    end
    if (acc < 0) acc = 0;
    if (acc > 180 * 65536) acc = 180 * 65536;
    return acc;
  endfunction

  function void note_pixel(logic [7:0] b8, logic [7:0] g8, logic [7:0] r8);
    longint b, g, r, sum, mn, x, y, a, h, q, d;
    hsi_t e;
    b = b8; g = g8; r = r8;
    sum = b + g + r;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    e = '0;
    // grey pixel keeps hue zero
    if (!(r == g && g == b)) begin
      x = (2 * r - g - b) * 64'sd16777216;
      d = g - b;
      y = (d < 0 ? -d : d) * 64'sd29058991;
      a = cordic_angle(x, y);
      h = (b <= g) ? a : 360 * 65536 - a;
      q = (h + 65536) / (2 * 65536);
      if (q > 255) q = 255;
      e.hue = q[7:0];
    end
    // black pixel keeps saturation zero
    if (sum != 0) begin
      q = (510 * (sum - 3 * mn) + sum) / (2 * sum);
      if (q > 255) q = 255;
      e.sat = q[7:0];
    end
    q = (sum + 1) / 3;
    if (q > 255) q = 255;
    e.inten = q[7:0];
    pending.push_back(e);
  endfunction

  function void check_result(logic [7:0] hue, logic [7:0] sat, logic [7:0] inten);
    hsi_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result hue=%0d sat=%0d int=%0d", $time, hue, sat, inten);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (hue !== e.hue) begin
      $display("%0t: hue expected %0d actual %0d", $time, e.hue, hue);
      errors++;
    end
    if (sat !== e.sat) begin
      $display("%0t: saturation expected %0d actual %0d", $time, e.sat, sat);
      errors++;
    end
    if (inten !== e.inten) begin
      $display("%0t: intensity expected %0d actual %0d", $time, e.inten, inten);
      errors++;
    end
  endfunction
endclass

module tb_rgb_to_hsi_pixel;
  import rgbhsi_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_hue_half_deg;
  logic [7:0] out_saturation;
  logic [7:0] out_intensity;

  hsi_scoreboard board;
  bit            calm;       // set for the final stretch: no idling on either side
  bit            inputs_done;

  rgb_to_hsi_pixel dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hue_half_deg(out_hue_half_deg), .out_saturation(out_saturation),
    .out_intensity(out_intensity)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Present one pixel at the falling edge; hold it until the transaction completes.
  // Valid stays high afterwards so back-to-back pixels need no gap.
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pixel(b, g, r);
    @(negedge clk);
  endtask

  // Drop valid after the last pixel of a stream.
  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Pixel that is well formed but biased toward interesting shapes: greys, near-greys,
  // a zero channel, a saturated green channel, equal green and blue.
  task automatic send_random_pixel();
    logic [7:0] b, g, r;
    b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
    case ($urandom_range(0, 7))
      0: begin g = b; r = b; end
      1: begin
        g = b + 8'($urandom_range(0, 2)) - 8'd1;
        r = b + 8'($urandom_range(0, 2)) - 8'd1;
      end
      2: b = 8'd0;
      3: begin g = 8'd255; b = b & 8'h0f; end
      4: g = b;
      default: ;
    endcase
    send_pixel(b, g, r);
  endtask

  // Output side: random ready bursts, sampled at the rising edge.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 10);
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_hue_half_deg, out_saturation, out_intensity);
  end

  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int settle;
    board       = new();
    calm        = 1'b0;
    inputs_done = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_blue     = 8'd0;
    in_green    = 8'd0;
    in_red      = 8'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: black, white, greys, primaries, mirrored hue, ties near 180.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd255);
    send_pixel(8'd0, 8'd128, 8'd64);
    send_pixel(8'd0, 8'd0, 8'd128);
    send_pixel(8'd1, 8'd2, 8'd3);
    send_pixel(8'haa, 8'h55, 8'haa);
    send_pixel(8'h55, 8'haa, 8'h55);
    stop_sending();

    // Drain completely once before the random stream.
    while (board.pending.size() != 0) @(posedge clk);
    @(negedge clk);

    for (int n = 0; n < 1800; n++) begin
      if (n == 1500) calm = 1'b1;
      send_random_pixel();
    end
    stop_sending();
    inputs_done = 1'b1;

    settle = 0;
    while (board.pending.size() != 0 && settle < 20000) begin
      @(posedge clk);
      settle++;
    end
    repeat (NumIter + 10) @(posedge clk);
    if (board.pending.size() == 0 && board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/rgbhsi_pkg.sv
rtl/rgbhsi_front.sv
rtl/rgbhsi_cell.sv
rtl/rgb_to_hsi_pixel.sv
test/tb_rgb_to_hsi_pixel.sv
